FILE: rtl/core/plc_pkg.sv
package plc_pkg;

    localparam int KNOT_BITS   = 8;
    localparam int REG_W       = 48;
    localparam int NUM_KNOTS_D = 6;
    localparam int LEVELS      = 256;
    localparam int PRODUCT_W   = 2 * KNOT_BITS;
    localparam int RES_W       = PRODUCT_W + 2;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 64;

    localparam logic [REG_W-1:0] KNOT_X_RESET = 48'hFFC896643200;
    localparam logic [REG_W-1:0] KNOT_Y_RESET = 48'hFF964B281400;

    localparam logic [ADDR_W-1:0] ADDR_KNOT_X = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_KNOT_Y = 4'h8;

    typedef struct packed {
        logic [KNOT_BITS-1:0] level;
        logic                 found;
        logic                 direct;
        logic [KNOT_BITS-1:0] ydir;
        logic [KNOT_BITS-1:0] x0;
        logic [KNOT_BITS-1:0] x1;
        logic [KNOT_BITS-1:0] y0;
        logic [KNOT_BITS-1:0] y1;
    } search_word_t;

    typedef struct packed {
        logic [PRODUCT_W-1:0] num;
        logic [KNOT_BITS-1:0] rem;
        logic [PRODUCT_W-1:0] quo;
        logic [KNOT_BITS-1:0] dvs;
        logic                 neg;
        logic [KNOT_BITS-1:0] y0;
        logic                 direct;
        logic [KNOT_BITS-1:0] ydir;
    } div_word_t;

    function automatic logic [KNOT_BITS-1:0] knot_field(input logic [REG_W-1:0] packed_val,
                                                        input int k);
        logic [KNOT_BITS-1:0] f;
        f = '0;
        if (k * KNOT_BITS < REG_W)
        begin
            f = packed_val[k*KNOT_BITS +: KNOT_BITS];
        end
        return f;
    endfunction

endpackage

FILE: rtl/core/plc_search_cell.sv
module plc_search_cell
    import plc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 is_first,
    input  logic [KNOT_BITS-1:0] x_prev,
    input  logic [KNOT_BITS-1:0] x_cur,
    input  logic [KNOT_BITS-1:0] y_prev,
    input  logic [KNOT_BITS-1:0] y_cur,
    input  logic                 in_valid,
    input  search_word_t         in_word,
    input  logic                 hold_in,
    output logic                 hold_out,
    output logic                 out_valid,
    output search_word_t         out_word
);

    logic         valid_reg;
    search_word_t word_reg;
    search_word_t word_next;

    assign hold_out  = valid_reg && hold_in;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        word_next = in_word;
        if (!in_word.found && in_word.level <= x_cur)
        begin
            word_next.found = 1'b1;
            word_next.x0    = x_prev;
            word_next.x1    = x_cur;
            word_next.y0    = y_prev;
            word_next.y1    = y_cur;
            word_next.ydir  = y_cur;
            word_next.direct = is_first || (in_word.level == x_cur);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!hold_out)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold_out)
        begin
            word_reg <= word_next;
        end
    end

endmodule

FILE: rtl/core/plc_div_cell.sv
module plc_div_cell
    import plc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  div_word_t in_word,
    input  logic      hold_in,
    output logic      hold_out,
    output logic      out_valid,
    output div_word_t out_word
);

    logic               valid_reg;
    div_word_t          word_reg;
    div_word_t          word_next;
    logic [KNOT_BITS:0] trial;
    logic [KNOT_BITS:0] diff;

    assign hold_out  = valid_reg && hold_in;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        word_next     = in_word;
        trial         = {in_word.rem, in_word.num[PRODUCT_W-1]};
        diff          = trial - {1'b0, in_word.dvs};
        word_next.num = {in_word.num[PRODUCT_W-2:0], 1'b0};
        if (trial >= {1'b0, in_word.dvs})
        begin
            word_next.rem = diff[KNOT_BITS-1:0];
            word_next.quo = {in_word.quo[PRODUCT_W-2:0], 1'b1};
        end
        else
        begin
            word_next.rem = trial[KNOT_BITS-1:0];
            word_next.quo = {in_word.quo[PRODUCT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!hold_out)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold_out)
        begin
            word_reg <= word_next;
        end
    end

endmodule

FILE: rtl/core/piecewise_linear_tone_curve.sv
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tdata[7:0] = level
// m_*       out        m_tvalid/m_tready  m_tdata[7:0] = mapped_level
// APB       in/out     psel/penable       knot_x_packed at 0x0, knot_y_packed at 0x8
//
// One word is accepted per cycle while s_tready is high; each word passes through every stage in order.
// The pipeline is one search cell per knot, a multiply stage, sixteen
// divider cells (one quotient bit each) and the output register.
// Reset clears all valid flags and loads the default knots.
// A stall on the output side fills empty stages first; s_tready falls only when
// every stage holds a word.
module piecewise_linear_tone_curve
    import plc_pkg::*;
#(
    parameter int NUM_KNOTS = NUM_KNOTS_D
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] level
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] mapped_level
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [REG_W-1:0] knot_x_reg;
    logic [REG_W-1:0] knot_y_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knot_x_reg <= KNOT_X_RESET;
            knot_y_reg <= KNOT_Y_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr)
                ADDR_KNOT_X: knot_x_reg <= pwdata[REG_W-1:0];
                ADDR_KNOT_Y: knot_y_reg <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_KNOT_X: prdata = {{(DATA_W-REG_W){1'b0}}, knot_x_reg};
            ADDR_KNOT_Y: prdata = {{(DATA_W-REG_W){1'b0}}, knot_y_reg};
            default:     prdata = '0;
        endcase
    end

    logic         s_valid [0:NUM_KNOTS];
    search_word_t s_word  [0:NUM_KNOTS];
    logic         s_hold  [0:NUM_KNOTS];
    search_word_t s_word_first;

    logic         mul_valid_reg;
    div_word_t    mul_word_reg;
    div_word_t    mul_word_next;
    logic         mul_hold;

    logic         d_valid [0:PRODUCT_W];
    div_word_t    d_word  [0:PRODUCT_W];
    logic         d_hold  [0:PRODUCT_W];

    logic             out_valid_reg;
    logic [7:0]       out_data_reg;
    logic [7:0]       out_data_next;
    logic             out_hold;

    always_comb
    begin
        s_word_first       = '0;
        s_word_first.level = s_tdata;
    end

    assign s_word[0]  = s_word_first;
    assign s_valid[0] = s_tvalid;

    assign s_tready = !s_hold[0];

    for (genvar k = 0; k < NUM_KNOTS; k++)
    begin : g_search
        localparam int KP = (k == 0) ? 0 : k - 1;
        plc_search_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .is_first ((k == 0) ? 1'b1 : 1'b0),
            .x_prev   (knot_field(knot_x_reg, KP)),
            .x_cur    (knot_field(knot_x_reg, k)),
            .y_prev   (knot_field(knot_y_reg, KP)),
            .y_cur    (knot_field(knot_y_reg, k)),
            .in_valid (s_valid[k]),
            .in_word  (s_word[k]),
            .hold_in  (s_hold[k+1]),
            .hold_out (s_hold[k]),
            .out_valid(s_valid[k+1]),
            .out_word (s_word[k+1])
        );
    end

    assign mul_hold          = mul_valid_reg && d_hold[0];
    assign s_hold[NUM_KNOTS] = mul_hold;

    always_comb
    begin
        logic [KNOT_BITS-1:0] dx;
        logic [KNOT_BITS-1:0] dy_mag;
        logic                 dy_neg;
        search_word_t         w;
        w      = s_word[NUM_KNOTS];
        dx     = w.level - w.x0;
        dy_neg = w.y1 < w.y0;
        dy_mag = dy_neg ? (w.y0 - w.y1) : (w.y1 - w.y0);
        mul_word_next        = '0;
        mul_word_next.num    = {{KNOT_BITS{1'b0}}, dx} * {{KNOT_BITS{1'b0}}, dy_mag};
        mul_word_next.dvs    = w.x1 - w.x0;
        mul_word_next.neg    = dy_neg;
        mul_word_next.y0     = w.y0;
        mul_word_next.direct = w.direct || !w.found;
        mul_word_next.ydir   = w.found ? w.ydir : knot_field(knot_y_reg, NUM_KNOTS - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (!mul_hold)
        begin
            mul_valid_reg <= s_valid[NUM_KNOTS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!mul_hold)
        begin
            mul_word_reg <= mul_word_next;
        end
    end

    assign d_valid[0] = mul_valid_reg;
    assign d_word[0]  = mul_word_reg;

    for (genvar b = 0; b < PRODUCT_W; b++)
    begin : g_div
        plc_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (d_valid[b]),
            .in_word  (d_word[b]),
            .hold_in  (d_hold[b+1]),
            .hold_out (d_hold[b]),
            .out_valid(d_valid[b+1]),
            .out_word (d_word[b+1])
        );
    end

    assign out_hold          = out_valid_reg && !m_tready;
    assign d_hold[PRODUCT_W] = out_hold;

    always_comb
    begin
        logic [PRODUCT_W:0]      q_up;
        logic signed [RES_W-1:0] q_s;
        logic signed [RES_W-1:0] sum;
        div_word_t               w;
        w    = d_word[PRODUCT_W];
        q_up = {1'b0, w.quo} + {{PRODUCT_W{1'b0}}, |w.rem};
        q_s  = w.neg ? -$signed({1'b0, q_up}) : $signed({2'b00, w.quo});
        sum  = q_s + $signed({{(RES_W-KNOT_BITS){1'b0}}, w.y0});
        if (w.direct)
        begin
            out_data_next = w.ydir;
        end
        else if (sum < 0)
        begin
            out_data_next = '0;
        end
        else if (sum > $signed(RES_W'(LEVELS - 1)))
        begin
            out_data_next = 8'(LEVELS - 1);
        end
        else
        begin
            out_data_next = sum[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_hold)
        begin
            out_valid_reg <= d_valid[PRODUCT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_hold)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: tb/sv/piecewise_linear_tone_curve_tb.sv
`timescale 1ns / 100ps

module piecewise_linear_tone_curve_tb;
    import plc_pkg::*;

    localparam int LATENCY    = NUM_KNOTS_D + 18;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [KNOT_BITS-1:0] level;
        logic [KNOT_BITS-1:0] mapped;
    } tone_word_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = '0;   // [7:0] level
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;         // [7:0] mapped_level
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [DATA_W-1:0] pwdata   = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic [KNOT_BITS-1:0] pending_levels[$];
    tone_word_t           expected_tones[$];
    logic [REG_W-1:0]     curve_x = KNOT_X_RESET;
    logic [REG_W-1:0]     curve_y = KNOT_Y_RESET;
    logic                 gaps_on = 1'b0;
    int                   mismatches = 0;
    int                   words_checked = 0;
    int                   curves_run = 0;
    int                   stall_cycles = 0;

    piecewise_linear_tone_curve DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    function automatic int knot_byte(input logic [REG_W-1:0] regv, input int k);
        return int'(regv[k*KNOT_BITS +: KNOT_BITS]);
    endfunction

    // Interpolation on the segment that ends at the first knot not below the level,
    // with the quotient floored toward minus infinity on falling segments.
    function automatic logic [KNOT_BITS-1:0] tone_map(input logic [KNOT_BITS-1:0] lvl,
                                                      input logic [REG_W-1:0] xs,
                                                      input logic [REG_W-1:0] ys);
        int j;
        int lv;
        int lo_x;
        int hi_x;
        int lo_y;
        int hi_y;
        int num;
        int den;
        int res;
        lv = int'(lvl);
        j = 0;
        while (j < NUM_KNOTS_D && lv > knot_byte(xs, j))
        begin
            j++;
        end
        if (j >= NUM_KNOTS_D)
        begin
            res = knot_byte(ys, NUM_KNOTS_D - 1);
        end
        else if (lv == knot_byte(xs, j) || j == 0)
        begin
            res = knot_byte(ys, j);
        end
        else
        begin
            lo_x = knot_byte(xs, j - 1);
            hi_x = knot_byte(xs, j);
            lo_y = knot_byte(ys, j - 1);
            hi_y = knot_byte(ys, j);
            num = (lv - lo_x) * (hi_y - lo_y);
            den = hi_x - lo_x;
            res = lo_y + ((num >= 0) ? num / den : -((-num + den - 1) / den));
        end
        if (res < 0)
        begin
            res = 0;
        end
        if (res > LEVELS - 1)
        begin
            res = LEVELS - 1;
        end
        return res[KNOT_BITS-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_levels.size() != 0 && (!gaps_on || $urandom_range(99) >= 17))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_levels.pop_front();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= !gaps_on || ($urandom_range(99) >= 17);
        end
    end

    always @(posedge clk)
    begin
        tone_word_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_tones.push_back('{level: s_tdata,
                                           mapped: tone_map(s_tdata, curve_x, curve_y)});
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_tones.size() == 0)
                begin
                    $display("%0t: unexpected word, mapped_level %0d", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_tones.pop_front();
                    words_checked++;
                    if (m_tdata !== want.mapped)
                    begin
                        $display("%0t: level %0d, mapped_level expected %0d, actual %0d",
                                 $time, want.level, want.mapped, m_tdata);
                        mismatches++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (pending_levels.size() == 0 && expected_tones.size() == 0 && !s_tvalid))
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("[piecewise_linear_tone_curve] ERROR");
        $finish;
    end

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [REG_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_KNOT_X)
        begin
            curve_x = value;
        end
        else if (addr == ADDR_KNOT_Y)
        begin
            curve_y = value;
        end
    endtask

    task automatic drain();
        while (pending_levels.size() != 0 || expected_tones.size() != 0 || s_tvalid)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic run_curve(input bit load, input logic [REG_W-1:0] xs,
                             input logic [REG_W-1:0] ys, input bit gaps, input int n_random);
        int k;
        int v;
        drain();
        if (load)
        begin
            write_reg(ADDR_KNOT_X, xs);
            write_reg(ADDR_KNOT_Y, ys);
        end
        curves_run++;
        @(posedge clk);
        gaps_on <= gaps;
        pending_levels.push_back(8'd0);
        pending_levels.push_back(8'd255);
        pending_levels.push_back(8'd128);
        pending_levels.push_back(8'h55);
        pending_levels.push_back(8'hAA);
        for (k = 0; k < NUM_KNOTS_D; k++)
        begin
            v = knot_byte(curve_x, k);
            pending_levels.push_back(8'(v - 1));
            pending_levels.push_back(8'(v));
            pending_levels.push_back(8'(v + 1));
        end
        for (k = 0; k < n_random; k++)
        begin
            if ($urandom_range(3) == 0)
            begin
                v = knot_byte(curve_x, $urandom_range(NUM_KNOTS_D - 1));
                pending_levels.push_back(8'(v + $urandom_range(4) - 2));
            end
            else
            begin
                pending_levels.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        logic [255:0]     picked;
        logic [REG_W-1:0] xs;
        int               cnt;
        int               v;
        int               n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        run_curve(1'b0, KNOT_X_RESET, KNOT_Y_RESET, 1'b0, 100);
        run_curve(1'b1, 48'hFFFEFD020100, 48'h00FF00FF00FF, 1'b1, 60);
        run_curve(1'b1, 48'hFAC8783D3C0A, 48'hC8078000FF00, 1'b1, 60);
        run_curve(1'b1, 48'h00FF96C83264, 48'h3CFA5A05DC1E, 1'b1, 60);
        run_curve(1'b1, 48'h000000000000, 48'h000000000000, 1'b1, 60);
        run_curve(1'b1, 48'hFFFFFFFFFFFF, 48'hFFFFFFFFFFFF, 1'b1, 60);
        run_curve(1'b1, KNOT_X_RESET, KNOT_Y_RESET, 1'b1, 60);

        for (n = 0; n < 4; n++)
        begin
            picked = '0;
            cnt = 0;
            while (cnt < NUM_KNOTS_D)
            begin
                v = $urandom_range(255);
                if (!picked[v])
                begin
                    picked[v] = 1'b1;
                    cnt++;
                end
            end
            cnt = 0;
            xs = '0;
            for (v = 0; v < 256; v++)
            begin
                if (picked[v])
                begin
                    xs[cnt*KNOT_BITS +: KNOT_BITS] = 8'(v);
                    cnt++;
                end
            end
            run_curve(1'b1, xs, REG_W'({$urandom, $urandom}), n != 0, 50);
        end

        // Knots in no particular order.
        for (n = 0; n < 2; n++)
        begin
            run_curve(1'b1, REG_W'({$urandom, $urandom}), REG_W'({$urandom, $urandom}),
                      1'b1, 40);
        end

        drain();
        repeat (2 * LATENCY) @(posedge clk);
        $display("Checked %0d mapped levels across %0d tone curves, including falling,",
                 words_checked, curves_run);
        $display("flat, unordered and random curves, with and without stalls on both sides.");
        if (mismatches == 0)
        begin
            $display("[piecewise_linear_tone_curve] OK");
        end
        else
        begin
            $display("[piecewise_linear_tone_curve] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/plc_pkg.sv
rtl/core/plc_search_cell.sv
rtl/core/plc_div_cell.sv
rtl/core/piecewise_linear_tone_curve.sv
tb/sv/piecewise_linear_tone_curve_tb.sv
